// ===== src/ps2m_pkg.sv =====
// ps2m_pkg: shared types and codes for the ps/2 mouse packet decoder
// used by ps2m_assembler, ps2m_emitter and ps2_mouse_packet_decoder
package ps2m_pkg;

    // result kinds
    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_MOVE   = 1'b1;

    // button codes
    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    // position of the next byte within a packet
    typedef enum logic [3:0] {
        POS_FLAG = 4'b0001,
        POS_X    = 4'b0010,
        POS_Y    = 4'b0100,
        POS_Z    = 4'b1000
    } t_pos;

    // one finished packet handed from the assembler to the emitter
    typedef struct packed {
        logic              load;
        logic [2:0]        chg;    // buttons that changed: bit 0 left, 1 right, 2 middle
        logic [2:0]        btn;    // new button state
        logic signed [8:0] mx;
        logic signed [8:0] my;
        logic signed [7:0] mz;
    } t_run;

endpackage

// ===== src/ps2_mouse_packet_decoder.sv =====
// ps2_mouse_packet_decoder: top level of the ps/2 mouse packet decoder
// depends on ps2m_pkg, ps2m_assembler and ps2m_emitter

// Takes mouse bytes one per transfer and groups them into three-byte packets,
// or four-byte wheel packets when the configuration bit is set. Every byte
// passes through the input register; a non-closing byte moves on in the next
// cycle. The closing byte of a packet hands a whole run to the output side,
// which sends one result per cycle while the receiver does not stall: a button
// event for each of left, right and middle that changed, then the movement
// report with o_last set. A run of 1 to 4 results holds the output side until
// its last result is taken. The closing byte of the next packet waits in the
// input register until the last result of the previous run has moved into the
// output register. Each result is built from the run held in the emitter's run
// registers and then registered in the output register. The configuration bit
// is written with i_cfg_we.
module ps2_mouse_packet_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_kind,
    output logic [1:0]        o_button,
    output logic              o_pressed,
    output logic signed [8:0] o_move_x,
    output logic signed [8:0] o_move_y,
    output logic signed [7:0] o_move_z,
    output logic              o_last
);
    import ps2m_pkg::*;

    t_run run;
    logic run_free;

    ps2m_assembler u_assembler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_run_free  (run_free),
        .o_run       (run)
    );

    ps2m_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_run      (run),
        .o_run_free (run_free),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_kind     (o_kind),
        .o_button   (o_button),
        .o_pressed  (o_pressed),
        .o_move_x   (o_move_x),
        .o_move_y   (o_move_y),
        .o_move_z   (o_move_z),
        .o_last     (o_last)
    );

endmodule

// ===== src/ps2m_assembler.sv =====
// ps2m_assembler: input register, byte position tracking and packet assembly
// depends on ps2m_pkg
module ps2m_assembler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_data_byte,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_run_free,
    output ps2m_pkg::t_run o_run
);
    import ps2m_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_four;
    t_pos       r_pos;
    t_pos       n_pos;
    logic [7:0] r_flag;
    logic [7:0] r_x;
    logic [7:0] r_y;
    logic [2:0] r_held;
    logic       final_byte;
    logic       consume;

    assign final_byte = (r_pos == POS_Z) || ((r_pos == POS_Y) && !r_four);
    // a closing byte waits until the emitter has room for the whole run
    assign consume    = r_in_valid && (!final_byte || i_run_free);
    assign o_stall    = r_in_valid && !consume;

    always_comb begin
        case (r_pos)
            POS_FLAG: n_pos = POS_X;
            POS_X:    n_pos = POS_Y;
            POS_Y:    n_pos = r_four ? POS_Z : POS_FLAG;
            POS_Z:    n_pos = POS_FLAG;
            default:  n_pos = POS_FLAG;
        endcase
    end

    always_comb begin
        o_run.load = consume && final_byte;
        o_run.chg  = r_flag[2:0] ^ r_held;
        o_run.btn  = r_flag[2:0];
        o_run.mx   = {r_flag[4], r_x};
        if (r_pos == POS_Z) begin
            o_run.my = {r_flag[5], r_y};
            // length cleared mid-packet: wheel byte dropped
            o_run.mz = r_four ? r_in_byte : 8'sd0;
        end else begin
            o_run.my = {r_flag[5], r_in_byte};
            o_run.mz = 8'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_four     <= 1'b0;
            r_pos      <= POS_FLAG;
            r_held     <= 3'b000;
        end else begin
            if (i_cfg_we) begin
                r_four <= i_cfg_wdata;
            end
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_pos <= n_pos;
            end
            if (o_run.load) begin
                r_held <= r_flag[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
        end
        if (consume) begin
            case (r_pos)
                POS_FLAG: r_flag <= r_in_byte;
                POS_X:    r_x    <= r_in_byte;
                POS_Y:    r_y    <= r_in_byte;
                default:  ;
            endcase
        end
    end

`ifndef SYNTH
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("stall raised with empty input register");

    a_held_only_on_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_held != $past(r_held))) |-> $past(o_run.load))
        else $error("button state changed outside a packet end");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run.load |-> i_run_free)
        else $error("packet handed over while emitter busy");
`endif

endmodule

// ===== src/ps2m_emitter.sv =====
// ps2m_emitter: holds one finished packet and sends its results one per transfer
// depends on ps2m_pkg
module ps2m_emitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ps2m_pkg::t_run    i_run,
    output logic              o_run_free,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_kind,
    output logic [1:0]        o_button,
    output logic              o_pressed,
    output logic signed [8:0] o_move_x,
    output logic signed [8:0] o_move_y,
    output logic signed [7:0] o_move_z,
    output logic              o_last
);
    import ps2m_pkg::*;

    logic              r_move;
    logic [2:0]        r_chg;
    logic [2:0]        r_btn;
    logic signed [8:0] r_mx;
    logic signed [8:0] r_my;
    logic signed [7:0] r_mz;

    logic              r_o_valid;
    logic              r_kind;
    logic [1:0]        r_button;
    logic              r_pressed;
    logic signed [8:0] r_ox;
    logic signed [8:0] r_oy;
    logic signed [7:0] r_oz;
    logic              r_last;

    logic              take;
    logic              n_kind;
    logic [1:0]        n_button;
    logic              n_pressed;
    logic              n_last;
    logic [2:0]        n_chg;

    assign o_run_free = !r_move;
    // output register free or being drained this cycle
    assign take = r_move && (!r_o_valid || !i_stall);

    // pick the next result: left, right, middle changes, then movement
    always_comb begin
        n_chg     = r_chg;
        n_kind    = KIND_BUTTON;
        n_button  = BTN_LEFT;
        n_pressed = 1'b0;
        n_last    = 1'b0;
        if (r_chg[0]) begin
            n_pressed = r_btn[0];
            n_chg[0]  = 1'b0;
        end else if (r_chg[1]) begin
            n_button  = BTN_RIGHT;
            n_pressed = r_btn[1];
            n_chg[1]  = 1'b0;
        end else if (r_chg[2]) begin
            n_button  = BTN_MIDDLE;
            n_pressed = r_btn[2];
            n_chg[2]  = 1'b0;
        end else begin
            n_kind = KIND_MOVE;
            n_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_run.load) begin
                r_move <= 1'b1;
            end else if (take && n_last) begin
                r_move <= 1'b0;
            end
            if (take) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run.load) begin
            r_chg <= i_run.chg;
            r_btn <= i_run.btn;
            r_mx  <= i_run.mx;
            r_my  <= i_run.my;
            r_mz  <= i_run.mz;
        end else if (take) begin
            r_chg <= n_chg;
        end
        if (take) begin
            r_kind    <= n_kind;
            r_button  <= n_button;
            r_pressed <= n_pressed;
            r_last    <= n_last;
            r_ox      <= n_last ? r_mx : 9'sd0;
            r_oy      <= n_last ? r_my : 9'sd0;
            r_oz      <= n_last ? r_mz : 8'sd0;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_kind    = r_kind;
    assign o_button  = r_button;
    assign o_pressed = r_pressed;
    assign o_move_x  = r_ox;
    assign o_move_y  = r_oy;
    assign o_move_z  = r_oz;
    assign o_last    = r_last;

`ifndef SYNTH
    a_last_is_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_kind == KIND_MOVE)))
        else $error("last flag does not match result kind");

    a_button_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_BUTTON)) |->
            (o_button == BTN_LEFT || o_button == BTN_RIGHT || o_button == BTN_MIDDLE))
        else $error("button event with bad button code");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_run.load |-> !r_move)
        else $error("packet loaded over a pending one");
`endif

endmodule

// ===== bench/tb_ps2_mouse_packet_decoder.sv =====
`timescale 1ns / 100ps
// tb_ps2_mouse_packet_decoder: self-checking bench for the ps/2 mouse packet decoder
// depends on ps2m_pkg and ps2_mouse_packet_decoder
module tb_ps2_mouse_packet_decoder;
    import ps2m_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 23;

    typedef struct packed {
        logic              kind;
        logic [1:0]        button;
        logic              pressed;
        logic signed [8:0] move_x;
        logic signed [8:0] move_y;
        logic signed [7:0] move_z;
        logic              last;
    } t_mouse_report;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic [7:0]        i_data_byte = 8'h00;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_wdata = 1'b0;
    logic              i_stall     = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_kind;
    logic [1:0]        o_button;
    logic              o_pressed;
    logic signed [8:0] o_move_x;
    logic signed [8:0] o_move_y;
    logic signed [7:0] o_move_z;
    logic              o_last;

    // predictor state
    t_pos       pkt_pos    = POS_FLAG;
    logic [7:0] flag_q     = 8'h00;
    logic [7:0] x_q        = 8'h00;
    logic [7:0] y_q        = 8'h00;
    logic [2:0] held_q     = 3'b000;
    logic       wheel_mode = 1'b0;

    t_mouse_report expected_reports[$];

    int  n_fail         = 0;
    int  bytes_sent     = 0;
    int  reports_seen   = 0;
    int  cycles         = 0;
    int  stall_hold_req = 0;
    int  hold_count     = 0;
    bit  calm           = 1'b0;

    ps2_mouse_packet_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_button    (o_button),
        .o_pressed   (o_pressed),
        .o_move_x    (o_move_x),
        .o_move_y    (o_move_y),
        .o_move_z    (o_move_z),
        .o_last      (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_reports.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- prediction ----------------

    function automatic void note_button(input int idx, input logic [1:0] code);
        t_mouse_report ev;
        if (flag_q[idx] != held_q[idx]) begin
            held_q[idx] = flag_q[idx];
            ev = '0;
            ev.kind    = KIND_BUTTON;
            ev.button  = code;
            ev.pressed = flag_q[idx];
            expected_reports.push_back(ev);
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        t_mouse_report mv;
        logic          closing;
        logic [7:0]    wheel;
        closing = 1'b0;
        wheel   = 8'h00;
        case (pkt_pos)
            POS_FLAG: begin
                flag_q  = b;
                pkt_pos = POS_X;
            end
            POS_X: begin
                x_q     = b;
                pkt_pos = POS_Y;
            end
            POS_Y: begin
                y_q = b;
                if (wheel_mode) begin
                    pkt_pos = POS_Z;
                end else begin
                    pkt_pos = POS_FLAG;
                    closing = 1'b1;
                end
            end
            default: begin
                // wheel byte is dropped if the length was cut back to three meanwhile
                pkt_pos = POS_FLAG;
                closing = 1'b1;
                wheel   = wheel_mode ? b : 8'h00;
            end
        endcase
        if (closing) begin
            note_button(0, BTN_LEFT);
            note_button(1, BTN_RIGHT);
            note_button(2, BTN_MIDDLE);
            mv = '0;
            mv.kind   = KIND_MOVE;
            mv.button = BTN_LEFT;
            mv.move_x = {flag_q[4], x_q};
            mv.move_y = {flag_q[5], y_q};
            mv.move_z = wheel;
            mv.last   = 1'b1;
            expected_reports.push_back(mv);
        end
    endfunction

    // ---------------- result checking ----------------

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_mouse_report exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $error("result with nothing expected: kind %0d button %0d",
                       o_kind, o_button);
                n_fail++;
            end else begin
                exp_r = expected_reports.pop_front();
                check_field("kind", exp_r.kind, o_kind);
                check_field("button", exp_r.button, o_button);
                check_field("pressed", exp_r.pressed, o_pressed);
                check_field("move_x", exp_r.move_x, o_move_x);
                check_field("move_y", exp_r.move_y, o_move_y);
                check_field("move_z", exp_r.move_z, o_move_z);
                check_field("last", exp_r.last, o_last);
            end
        end
    end

    // receiver side: random stall, quiet stretches, and a counted long hold-off
    always @(posedge i_clk) begin
        if (stall_hold_req > 0) begin
            hold_count     = stall_hold_req;
            stall_hold_req = 0;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_count > 0) begin
            i_stall <= 1'b1;
            hold_count--;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ---------------- sender side ----------------

    task automatic send_byte(input logic [7:0] b);
        // idle cycle by cycle with the same odds as the receiver
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        predict_byte(b);
        bytes_sent++;
    endtask

    // sender pause: all expected results in, then let any unfinished byte settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic four_bytes);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= four_bytes;
        @(posedge i_clk);
        wheel_mode = four_bytes;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_packet(input logic [7:0] f, input logic [7:0] x, input logic [7:0] y);
        send_byte(f);
        send_byte(x);
        send_byte(y);
    endtask

    // ---------------- tests ----------------

    task automatic test_three_byte_packets();
        // left press, no movement
        send_packet(8'h01, 8'h00, 8'h00);
        // right and middle press, both signs set, x and y of -1
        send_packet(8'h37, 8'hFF, 8'hFF);
        // all released, x most negative, y of 127
        send_packet(8'h10, 8'h00, 8'h7F);
        // overflow and always-one bits must not matter
        send_packet(8'hC8, 8'hFF, 8'h80);
        wait_idle();
    endtask

    task automatic test_wheel_packets();
        cfg_write(1'b1);
        send_packet(8'h2A, 8'h01, 8'h02);
        send_byte(8'h7F);
        send_packet(8'h1D, 8'h80, 8'h00);
        send_byte(8'h80);
        wait_idle();
    endtask

    task automatic test_length_change();
        // cut to three bytes after the y byte: next byte closes with no wheel
        send_packet(8'h07, 8'h10, 8'h20);
        wait_idle();
        cfg_write(1'b0);
        send_byte(8'h55);
        wait_idle();
        // cut back early: packet closes on its third byte
        cfg_write(1'b1);
        send_byte(8'h02);
        send_byte(8'h33);
        wait_idle();
        cfg_write(1'b0);
        send_byte(8'h44);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        cfg_write(1'b0);
        calm           = 1'b1;
        stall_hold_req = 300;
        repeat (24) send_byte(8'($urandom_range(255)));
        calm = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int phase;
        int count;
        for (phase = 0; phase < 8; phase++) begin
            if (phase % 2 == 0)
                cfg_write(1'($urandom_range(1)));
            else
                cfg_write(~wheel_mode);
            calm  = (phase == 3);
            // lengths that are not a multiple of the packet length leave packets open across the next register write
            count = $urandom_range(20, 40);
            repeat (count) send_byte(8'($urandom_range(255)));
            calm = 1'b0;
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_three_byte_packets();
        test_wheel_packets();
        test_length_change();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        $display("sent %0d bytes and checked %0d results over both packet lengths,",
                 bytes_sent, reports_seen);
        $display("mid-packet length changes, a long output hold-off and random idling");
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== ps2_mouse_packet_decoder.f =====
src/ps2m_pkg.sv
src/ps2m_assembler.sv
src/ps2m_emitter.sv
src/ps2_mouse_packet_decoder.sv
bench/tb_ps2_mouse_packet_decoder.sv
